// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a consequence holds in the cycle after its trigger.
`define ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/tsrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Timestamp record sorter package
// Beat types, chain control types, register indexes and states.
// ----------------------------------------------------------------------------
package tsrs_pkg;

	localparam int KEY_W     = 32;
	localparam int TAG_W     = 16;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SORT_BY_TIME  = 2'd0,
		REG_REVERSE_ORDER = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] time_stamp;
		logic        [TAG_W-1:0] entry_tag;
		logic                    last_entry;
	} in_beat_t;

	typedef struct packed {
		logic        [TAG_W-1:0] out_tag;
		logic signed [KEY_W-1:0] out_time;
		logic                    out_last;
		logic                    overflow;
	} out_beat_t;

	// One record as held in a cell.
	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic        [TAG_W-1:0] tag;
	} rec_t;

	// Ordering mode; the user must keep it fixed for the duration of a set (not enforced).
	typedef struct packed {
		logic sort_en;
		logic rev_en;
	} mode_t;

	// Chain-wide control, broadcast to every cell.
	typedef struct packed {
		logic ins_en;
		logic pop;
	} cell_ctl_t;

	typedef enum logic [0:0] {
		ST_LOAD  = 1'b0,
		ST_DRAIN = 1'b1
	} state_t;

endpackage

// ===== hw/rtl/tsrs_cell.sv =====
// ----------------------------------------------------------------------------
// Sorter cell
// Holds one record; inserts the broadcast record, shifts from its neighbors.
// ----------------------------------------------------------------------------
module tsrs_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  tsrs_pkg::mode_t   mode,
	input  tsrs_pkg::cell_ctl_t ctl,
	input  tsrs_pkg::rec_t    new_rec,
	input  logic              prev_ins,
	input  logic              prev_valid,
	input  tsrs_pkg::rec_t    prev_rec,
	input  logic              next_valid,
	input  tsrs_pkg::rec_t    next_rec,
	output logic              ins,
	output logic              valid,
	output tsrs_pkg::rec_t    rec
);
	import tsrs_pkg::*;

	logic valid_q;
	rec_t rec_q;
	logic goes_here;

	// Insertion point test: an empty cell always takes the record; with sort
	// the new record lands ahead of a strictly smaller key (descending) or
	// ahead of a key not below it (ascending, for the reversed list).
	always_comb begin
		if (!mode.sort_en) begin
			goes_here = mode.rev_en;
		end else if (mode.rev_en) begin
			goes_here = (new_rec.key <= rec_q.key);
		end else begin
			goes_here = (new_rec.key > rec_q.key);
		end
		ins = !valid_q || goes_here;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.pop) begin
			valid_q <= next_valid;
		end else if (ctl.ins_en) begin
			if (prev_ins) begin
				valid_q <= prev_valid;
			end else if (ins) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			rec_q <= next_rec;
		end else if (ctl.ins_en) begin
			if (prev_ins) begin
				rec_q <= prev_rec;
			end else if (ins) begin
				rec_q <= new_rec;
			end
		end
	end

	assign valid = valid_q;
	assign rec   = rec_q;

endmodule

// ===== hw/rtl/timestamp_record_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// Timestamp record sorter unit: one record beat per cycle while loading.
// First result in the cycle after the last-entry beat; results follow back to back unless stalled.
// Drain rate is set by the one-step shift of the cell chain; input stalls then.
// Reset clears cell valid bits, count, overflow flag, mode registers.
// ----------------------------------------------------------------------------
module timestamp_record_sorter_unit #(
	parameter int MAX_ENTRIES = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rec_valid,
	output logic                          rec_stall,
	input  tsrs_pkg::in_beat_t            rec_data,
	output logic                          res_valid,
	input  logic                          res_stall,
	output tsrs_pkg::out_beat_t           res_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tsrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic                          cfg_wdata
);
	import tsrs_pkg::*;

	`include "assert_macros.svh"

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	state_t           state_q;
	state_t           state_nxt;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	mode_t            mode_q;

	logic             rec_acc;
	logic             res_acc;
	logic             full;
	logic             drain_done;
	cell_ctl_t        ctl;
	rec_t             new_rec;

	logic [MAX_ENTRIES-1:0] cell_valid;
	logic [MAX_ENTRIES-1:0] cell_ins;
	rec_t                   cell_rec [MAX_ENTRIES];

	// Configuration: always ready; written only while idle between sets, by the user (not enforced).
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SORT_BY_TIME:  mode_q.sort_en <= cfg_wdata;
				REG_REVERSE_ORDER: mode_q.rev_en  <= cfg_wdata;
				default: ; // drop writes to unmapped indexes
			endcase
		end
	end

	// Handshakes.
	assign rec_acc    = rec_valid && !rec_stall;
	assign res_acc    = res_valid && !res_stall;
	assign full       = (count_q == CNT_W'(MAX_ENTRIES));
	assign drain_done = res_acc && (count_q == CNT_W'(1));

	// Chain control: insert while room is left, drop beats past capacity,
	// pop the head on every accepted result beat.
	assign ctl.ins_en = rec_acc && !full;
	assign ctl.pop    = res_acc;
	assign new_rec    = '{key: rec_data.time_stamp, tag: rec_data.entry_tag};

	// Sequencer: load until the last-entry beat, then drain the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		rec_stall = 1'b1;
		res_valid = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				rec_stall = 1'b0;
				if (rec_acc && rec_data.last_entry) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				res_valid = 1'b1;
				if (drain_done) begin
					state_nxt = ST_LOAD;
				end
			end
			default: state_nxt = ST_LOAD;
		endcase
	end

	// Record count and overflow flag; both return to zero after the final beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (ctl.ins_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.pop) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (rec_acc && full) begin
				ovf_q <= 1'b1;
			end else if (drain_done) begin
				ovf_q <= 1'b0;
			end
		end
	end

	// Cell chain: cell 0 is the head and the output register.
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic prev_ins;
		logic prev_valid;
		rec_t prev_rec;
		logic next_valid;
		rec_t next_rec;

		if (i == 0) begin : g_head
			assign prev_ins   = 1'b0;
			assign prev_valid = 1'b0;
			assign prev_rec   = new_rec;
		end else begin : g_body
			assign prev_ins   = cell_ins[i-1];
			assign prev_valid = cell_valid[i-1];
			assign prev_rec   = cell_rec[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign next_valid = 1'b0;
			assign next_rec   = cell_rec[i];
		end else begin : g_inner
			assign next_valid = cell_valid[i+1];
			assign next_rec   = cell_rec[i+1];
		end

		tsrs_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.mode       (mode_q),
			.ctl        (ctl),
			.new_rec    (new_rec),
			.prev_ins   (prev_ins),
			.prev_valid (prev_valid),
			.prev_rec   (prev_rec),
			.next_valid (next_valid),
			.next_rec   (next_rec),
			.ins        (cell_ins[i]),
			.valid      (cell_valid[i]),
			.rec        (cell_rec[i])
		);
	end

	// Result beat straight from the head cell; it holds while stalled.
	assign res_data = '{
		out_tag:  cell_rec[0].tag,
		out_time: cell_rec[0].key,
		out_last: (count_q == CNT_W'(1)),
		overflow: ovf_q
	};

	`ASSERT_PROP(a_count_bound, count_q <= CNT_W'(MAX_ENTRIES), "record count past capacity")
	`ASSERT_PROP(a_valid_count, $countones(cell_valid) == int'(count_q), "cell valids disagree with count")
	`ASSERT_PROP(a_head_valid, !res_valid || (cell_valid[0] && count_q != '0), "result from empty head")
	`ASSERT_NEXT(a_drain_clear, drain_done, state_q == ST_LOAD && count_q == '0 && !ovf_q, "set not cleared after final beat")

endmodule
